// ----- hw/rtl/mlps_pkg.sv -----
// Shared types, constants and the sigmoid table for the perceptron inference block.
`default_nettype none

package mlps_pkg;

  localparam int MAX_NEURONS   = 16;
  localparam int NEURON_W      = 4;
  localparam int CNT_W         = 5;
  localparam int LAYER_W       = 2;
  localparam int WEIGHT_LAYERS = 3;
  localparam int NUM_NEURON_REGS = 4;
  localparam int DATA_W        = 16;
  localparam int PROD_W        = 32;
  localparam int ACC_W         = 36;
  localparam int ACT_W         = 13;
  localparam int SIG_IDX_W     = 9;
  localparam int SIG_SHIFT     = 19;
  localparam int SIG_ENTRIES   = 512;
  localparam int WDEPTH        = WEIGHT_LAYERS * MAX_NEURONS * MAX_NEURONS;
  localparam int WADDR_W       = LAYER_W + 2 * NEURON_W;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 5;

  localparam logic signed [ACC_W-1:0] SUM_LO   = -(ACC_W'(64'sd1 <<< 27));
  localparam logic signed [ACC_W-1:0] SUM_HI   = ACC_W'((64'sd1 <<< 27) - 64'sd1);
  localparam logic        [ACC_W-1:0] SUM_BIAS = ACC_W'(64'd1 << 27);

  localparam logic [63:0] EXP_STEP_Q32 = 64'd4162825043;

  localparam logic REQ_WEIGHT = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] CFG_LAYER_COUNT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_NEURONS0    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_NEURONS1    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_NEURONS2    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_NEURONS3    = 3'd4;

  localparam logic [2:0] LAYERS_MIN   = 3'd2;
  localparam logic [2:0] LAYERS_MAX   = 3'd4;
  localparam logic [2:0] LAYERS_RESET = 3'd3;
  localparam logic [CNT_W-1:0] NEURONS_MIN = 5'd1;
  localparam logic [CNT_W-1:0] NEURONS_MAX = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                load_weight;
    logic                load_sample;
    logic                mac_issue;
    logic                mac_first;
    logic                mac_last;
    logic [LAYER_W-1:0]  layer;
    logic [NEURON_W-1:0] out_idx;
    logic [NEURON_W-1:0] in_idx;
    logic                copy;
    logic [CNT_W-1:0]    copy_count;
    logic                emit;
    logic                emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

  typedef logic [SIG_ENTRIES-1:0][ACT_W-1:0] sig_table_t;

  function automatic logic [2:0] sat_layers(input logic [2:0] v);
    logic [2:0] r;
    r = v;
    if (v < LAYERS_MIN) r = LAYERS_MIN;
    if (v > LAYERS_MAX) r = LAYERS_MAX;
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_neurons(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v < NEURONS_MIN) r = NEURONS_MIN;
    if (v > NEURONS_MAX) r = NEURONS_MAX;
    return r;
  endfunction

  // Entry i stands for x = (i - 256) / 32. The exponential is stepped in Q32 and
  // the reciprocal is formed by restoring division at elaboration.
  function automatic sig_table_t build_sig_table();
    sig_table_t          tbl;
    logic [256:0][ACT_W-1:0] s;
    logic [63:0]         e;
    logic [63:0]         d;
    logic [63:0]         rem;
    logic [63:0]         dsh;
    logic [ACT_W-1:0]    q;
    e = 64'd1 << 32;
    for (int k = 0; k <= 256; k++) begin
      d = (64'd1 << 32) + e;
      rem = (64'd1 << 44) + (d >> 1);
      q = '0;
      for (int b = ACT_W - 1; b >= 0; b--) begin
        dsh = d << b;
        if (rem >= dsh) begin
          rem = rem - dsh;
          q[b] = 1'b1;
        end
      end
      s[k] = q;
      e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      if (i >= 256) tbl[i] = s[i - 256];
      else tbl[i] = 13'd4096 - s[256 - i];
    end
    return tbl;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

// ----- hw/rtl/mlps_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module mlps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mlps_datapath.sv -----
// Datapath: weight store, activation and sum buffers, MAC pipeline, sigmoid lookup, result register.
`default_nettype none

module mlps_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  mlps_pkg::dp_cmd_t             cmd,
  output mlps_pkg::dp_status_t          status,
  input  logic [mlps_pkg::LAYER_W-1:0]  layer_index,
  input  logic [mlps_pkg::NEURON_W-1:0] out_index,
  input  logic [mlps_pkg::NEURON_W-1:0] in_index,
  input  logic signed [mlps_pkg::DATA_W-1:0] value,
  output logic                          result_strobe,
  output logic [mlps_pkg::NEURON_W-1:0] neuron_index,
  output logic [mlps_pkg::ACT_W-1:0]    activation,
  output logic                          last
);

  import mlps_pkg::*;

  logic signed [DATA_W-1:0] act_buf [MAX_NEURONS];
  logic [ACT_W-1:0]         sum_buf [MAX_NEURONS];

  logic                w_we;
  logic [WADDR_W-1:0]  w_waddr;
  logic [WADDR_W-1:0]  w_raddr;
  logic [DATA_W-1:0]   w_rdata;

  logic                     v1;
  logic                     first1;
  logic                     last1;
  logic [NEURON_W-1:0]      o1;
  logic signed [DATA_W-1:0] act1;

  logic                     v2;
  logic                     first2;
  logic                     last2;
  logic [NEURON_W-1:0]      o2;
  logic signed [PROD_W-1:0] prod;

  logic                     acc_v;
  logic                     acc_last;
  logic [NEURON_W-1:0]      o3;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;

  logic                     idx_v;
  logic [NEURON_W-1:0]      o4;
  logic [SIG_IDX_W-1:0]     sig_idx;
  logic [SIG_IDX_W-1:0]     sig_idx_next;
  logic [ACC_W-1:0]         biased;

  assign w_we    = cmd.load_weight && (layer_index < LAYER_W'(WEIGHT_LAYERS));
  assign w_waddr = {layer_index, out_index, in_index};
  assign w_raddr = {cmd.layer, cmd.out_idx, cmd.in_idx};

  mlps_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WDEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (value),
    .re    (cmd.mac_issue),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
  assign biased   = acc + SUM_BIAS;

  always_comb begin
    if (acc < SUM_LO) begin
      sig_idx_next = '0;
    end else if (acc > SUM_HI) begin
      sig_idx_next = '1;
    end else begin
      sig_idx_next = biased[SIG_SHIFT +: SIG_IDX_W];
    end
  end

  assign status.pipe_busy = v1 || v2 || acc_v || idx_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      acc_v         <= 1'b0;
      idx_v         <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      v1            <= cmd.mac_issue;
      v2            <= v1;
      acc_v         <= v2;
      idx_v         <= acc_v && acc_last;
      result_strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    first1   <= cmd.mac_first;
    last1    <= cmd.mac_last;
    o1       <= cmd.out_idx;
    act1     <= act_buf[cmd.in_idx];

    first2   <= first1;
    last2    <= last1;
    o2       <= o1;
    prod     <= act1 * $signed(w_rdata);

    acc_last <= last2;
    o3       <= o2;
    if (v2) begin
      acc <= first2 ? prod_ext : acc + prod_ext;
    end

    o4      <= o3;
    sig_idx <= sig_idx_next;

    if (idx_v) begin
      sum_buf[o4] <= SIG_TABLE[sig_idx];
    end

    if (cmd.load_sample) begin
      act_buf[in_index] <= value;
    end
    if (cmd.copy) begin
      for (int i = 0; i < MAX_NEURONS; i++) begin
        if (CNT_W'(i) < cmd.copy_count) begin
          act_buf[i] <= {{(DATA_W - ACT_W){1'b0}}, sum_buf[i]};
        end
      end
    end

    neuron_index <= cmd.out_idx;
    activation   <= sum_buf[cmd.out_idx];
    last         <= cmd.emit_last;
  end

  // A sigmoid index is formed only from a sum that just received its final term.
  assert property (@(posedge clk) disable iff (rst) idx_v |-> $past(acc_v && acc_last))
    else $error("sigmoid index without a completed sum");

  // The final beat of a run is never followed directly by another beat.
  assert property (@(posedge clk) disable iff (rst) (result_strobe && last) |=> !result_strobe)
    else $error("result beat right after the final beat");

endmodule

`default_nettype wire

// ----- hw/rtl/mlps_ctrl.sv -----
// Controller: configuration registers, layer and neuron sequencing, result emission.
`default_nettype none

module mlps_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            req_type,
  input  logic                            is_last,
  input  logic                            cfg_we,
  input  logic [mlps_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mlps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  mlps_pkg::dp_status_t            status,
  output mlps_pkg::dp_cmd_t               cmd,
  output logic                            busy
);

  import mlps_pkg::*;

  state_t state;
  state_t state_next;

  logic [2:0]          layers_cfg;
  logic [CNT_W-1:0]    neurons_cfg [NUM_NEURON_REGS];
  logic [LAYER_W-1:0]  l_cnt;
  logic [NEURON_W-1:0] o_cnt;
  logic [NEURON_W-1:0] j_cnt;
  logic [CNT_W-1:0]    n_in;
  logic [CNT_W-1:0]    n_out;

  logic accept;
  logic start_pass;
  logic j_last;
  logic o_last;
  logic layer_final;

  assign accept      = start && (state == ST_IDLE);
  assign start_pass  = accept && (req_type == REQ_SAMPLE) && is_last;
  assign j_last      = (CNT_W'(j_cnt) + 5'd1) == n_in;
  assign o_last      = (CNT_W'(o_cnt) + 5'd1) == n_out;
  assign layer_final = (3'(l_cnt) + 3'd2) == layers_cfg;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_pass) state_next = ST_MAC;
      end
      ST_MAC: begin
        if (j_last && o_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_next = layer_final ? ST_EMIT : ST_MAC;
      end
      ST_EMIT: begin
        if (o_last) state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.layer      = l_cnt;
    cmd.out_idx    = o_cnt;
    cmd.in_idx     = j_cnt;
    cmd.mac_first  = (j_cnt == '0);
    cmd.mac_last   = j_last;
    cmd.copy_count = n_out;
    busy           = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.load_weight = accept && (req_type == REQ_WEIGHT);
        cmd.load_sample = accept && (req_type == REQ_SAMPLE);
      end
      ST_MAC: begin
        cmd.mac_issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd.copy = !status.pipe_busy;
      end
      ST_EMIT: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = o_last;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      layers_cfg <= LAYERS_RESET;
      for (int i = 0; i < NUM_NEURON_REGS; i++) begin
        neurons_cfg[i] <= NEURONS_MAX;
      end
      l_cnt <= '0;
      o_cnt <= '0;
      j_cnt <= '0;
      n_in  <= NEURONS_MAX;
      n_out <= NEURONS_MAX;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_LAYER_COUNT: layers_cfg     <= sat_layers(cfg_wdata[2:0]);
          CFG_NEURONS0:    neurons_cfg[0] <= sat_neurons(cfg_wdata);
          CFG_NEURONS1:    neurons_cfg[1] <= sat_neurons(cfg_wdata);
          CFG_NEURONS2:    neurons_cfg[2] <= sat_neurons(cfg_wdata);
          CFG_NEURONS3:    neurons_cfg[3] <= sat_neurons(cfg_wdata);
          default: begin
          end
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (start_pass) begin
            l_cnt <= '0;
            o_cnt <= '0;
            j_cnt <= '0;
            n_in  <= neurons_cfg[0];
            n_out <= neurons_cfg[1];
          end
        end
        ST_MAC: begin
          if (j_last) begin
            j_cnt <= '0;
            o_cnt <= o_cnt + 4'd1;
          end else begin
            j_cnt <= j_cnt + 4'd1;
          end
        end
        ST_DRAIN: begin
          if (!status.pipe_busy) begin
            o_cnt <= '0;
            j_cnt <= '0;
            if (!layer_final) begin
              l_cnt <= l_cnt + 2'd1;
              n_in  <= n_out;
              n_out <= neurons_cfg[2'(l_cnt + 2'd2)];
            end
          end
        end
        ST_EMIT: begin
          o_cnt <= o_cnt + 4'd1;
        end
      endcase
    end
  end

  // The multiply-accumulate walk stays inside the current layer's sizes.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC) |-> ((CNT_W'(o_cnt) < n_out) && (CNT_W'(j_cnt) < n_in)))
    else $error("neuron counter outside the layer");

  // Layer sizes held for the pass are always legal.
  assert property (@(posedge clk) disable iff (rst)
    (n_in >= NEURONS_MIN) && (n_in <= NEURONS_MAX) && (n_out >= NEURONS_MIN) &&
    (n_out <= NEURONS_MAX))
    else $error("layer size out of range");

  // After the final result beat is issued the controller is idle again.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.emit_last) |=> (state == ST_IDLE))
    else $error("controller not idle after final beat");

endmodule

`default_nettype wire

// ----- hw/rtl/mlp_sigmoid_forward_pass.sv -----
// Top level of the sigmoid perceptron inference block.
//
// Items arrive on start with req_type, layer_index, out_index, in_index, value
// and is_last; an item is taken at a clock edge where start is high and busy is
// low. A weight item writes one Q4.12 weight; a sample item writes one input
// element. A sample item with is_last set starts a pass and raises busy until
// the last result beat has been issued. A pass runs each weight layer as
// nin * nout back-to-back multiply-accumulates on the single MAC pipeline and
// weight RAM read port, then drains the pipeline and moves the sums into the
// activation buffer. The output layer's n results then come one per cycle, each
// on the result ports for exactly one cycle with result_strobe high; the
// receiver cannot stall them. Configuration writes (cfg_we, cfg_addr,
// cfg_wdata) take effect at once and must be made while the block is idle;
// the block itself does not enforce this. Reset restores three layers of
// sixteen neurons and clears the controller; the weight store is undefined
// until written.
`default_nettype none

module mlp_sigmoid_forward_pass (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            req_type,
  input  logic [mlps_pkg::LAYER_W-1:0]    layer_index,
  input  logic [mlps_pkg::NEURON_W-1:0]   out_index,
  input  logic [mlps_pkg::NEURON_W-1:0]   in_index,
  input  logic signed [mlps_pkg::DATA_W-1:0] value,
  input  logic                            is_last,
  input  logic                            cfg_we,
  input  logic [mlps_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mlps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                            result_strobe,
  output logic [mlps_pkg::NEURON_W-1:0]   neuron_index,
  output logic [mlps_pkg::ACT_W-1:0]      activation,
  output logic                            last
);

  import mlps_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mlps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_type  (req_type),
    .is_last   (is_last),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  mlps_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .layer_index   (layer_index),
    .out_index     (out_index),
    .in_index      (in_index),
    .value         (value),
    .result_strobe (result_strobe),
    .neuron_index  (neuron_index),
    .activation    (activation),
    .last          (last)
  );

endmodule

`default_nettype wire
